// ===== src/hcb_pkg.sv =====
// package for the huffman code builder: sizes, sequencer steps and the
// command and status structs between controller and datapath; no dependencies
`default_nettype none

package hcb_pkg;

  localparam int unsigned MAX_SYMBOLS = 64;
  localparam int unsigned COUNT_BITS  = 24;
  localparam int unsigned NODE_MAX    = 2 * MAX_SYMBOLS - 1;
  localparam int unsigned SLOT_AW     = $clog2(MAX_SYMBOLS);
  localparam int unsigned CNT_W       = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned IDX_W       = $clog2(NODE_MAX);
  localparam int unsigned WEIGHT_W    = COUNT_BITS + SLOT_AW;
  localparam int unsigned DEPTH_W     = 6;
  localparam int unsigned CODE_W      = 63;
  localparam int unsigned SYM_W       = 32;
  localparam int unsigned BYTES_W     = 3;
  localparam int unsigned BSUM_W      = 36;
  localparam int unsigned ISUM_W      = 32;
  localparam int unsigned STORE_W     = SYM_W + BYTES_W;
  localparam int unsigned CHILD_W     = 2 * IDX_W;
  localparam int unsigned STACK_W     = IDX_W + DEPTH_W + CODE_W;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_INIT,
    OP_BLD_NEXT,
    OP_SIFT_LOAD,
    OP_SIFT_SLOT,
    OP_SIFT_WT,
    OP_SIFT_L,
    OP_SIFT_R,
    OP_SIFT_RW,
    OP_SIFT_PICK,
    OP_MERGE_CHK,
    OP_TAKE_TOP,
    OP_TAKE_LAST,
    OP_TAKE_MOVE,
    OP_TAKE_NEXT,
    OP_SUM_A,
    OP_SUM_B,
    OP_SUM_WR,
    OP_UP_CHK,
    OP_UP_SLOT,
    OP_UP_CMP,
    OP_NODE_NEXT,
    OP_WALK_ROOT,
    OP_WALK_PUSH0,
    OP_WALK_POP,
    OP_WALK_READ,
    OP_WALK_LEAF,
    OP_WALK_EMIT,
    OP_WALK_RIGHT,
    OP_WALK_LEFT,
    OP_FINISH
  } hcb_op_e;

  typedef enum logic [1:0] {
    RET_BUILD,
    RET_TAKE1,
    RET_TAKE2
  } hcb_ret_e;

  typedef struct packed {
    hcb_op_e op;
  } hcb_cmd_t;

  typedef struct packed {
    logic acc_last;
    logic init_done;
    logic one_sym;
    logic bld_zero;
    logic sift_end;
    logic sift_stay;
    logic fill_gt1;
    logic m_zero;
    logic up_less;
    logic sp_zero;
    logic is_leaf;
    logic emit_ok;
    logic out_free;
    logic pend_v;
  } hcb_sts_t;

endpackage

`default_nettype wire

// ===== src/hcb_in_if.sv =====
// input channel of the huffman code builder: valid, ready and one symbol beat
// no dependencies
`default_nettype none

interface hcb_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] symbol;
  logic [2:0]  symbol_bytes;
  logic [23:0] count;
  logic        last;

  modport source (output valid, symbol, symbol_bytes, count, last, input ready);
  modport sink   (input valid, symbol, symbol_bytes, count, last, output ready);
endinterface

`default_nettype wire

// ===== src/hcb_out_if.sv =====
// output channel of the huffman code builder: valid, ready and one code beat
// no dependencies
`default_nettype none

interface hcb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] symbol_res;
  logic [5:0]  code_length;
  logic [62:0] code_bits;
  logic [35:0] total_bits;
  logic [31:0] input_bytes;
  logic        last_res;

  modport source (output valid, symbol_res, code_length, code_bits, total_bits,
                  input_bytes, last_res, input ready);
  modport sink   (input valid, symbol_res, code_length, code_bits, total_bits,
                  input_bytes, last_res, output ready);
endinterface

`default_nettype wire

// ===== src/hcb_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module hcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/hcb_ctrl.sv =====
// sequencer of the huffman code builder: load, heap build, merges, tree walk
// depends on hcb_pkg
`default_nettype none

module hcb_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire hcb_pkg::hcb_sts_t sts_i,
  output hcb_pkg::hcb_cmd_t     cmd_o
);

  hcb_pkg::hcb_op_e  state_q, state_d;
  hcb_pkg::hcb_ret_e ret_q, ret_d;
  hcb_pkg::hcb_op_e  ret_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hcb_pkg::OP_IDLE;
      ret_q   <= hcb_pkg::RET_BUILD;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  always_comb begin
    unique case (ret_q)
      hcb_pkg::RET_BUILD: ret_op = sts_i.bld_zero ? hcb_pkg::OP_MERGE_CHK : hcb_pkg::OP_BLD_NEXT;
      hcb_pkg::RET_TAKE1: ret_op = hcb_pkg::OP_TAKE_NEXT;
      default:            ret_op = hcb_pkg::OP_SUM_A;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    cmd_o.op  = state_q;
    unique case (state_q)
      hcb_pkg::OP_IDLE: begin
        if (sts_i.acc_last) state_d = hcb_pkg::OP_INIT;
      end
      hcb_pkg::OP_INIT: begin
        if (sts_i.init_done) begin
          ret_d   = hcb_pkg::RET_BUILD;
          state_d = sts_i.one_sym ? hcb_pkg::OP_WALK_ROOT : hcb_pkg::OP_SIFT_LOAD;
        end
      end
      hcb_pkg::OP_BLD_NEXT:  state_d = hcb_pkg::OP_SIFT_LOAD;
      hcb_pkg::OP_SIFT_LOAD: state_d = hcb_pkg::OP_SIFT_SLOT;
      hcb_pkg::OP_SIFT_SLOT: state_d = hcb_pkg::OP_SIFT_WT;
      hcb_pkg::OP_SIFT_WT:   state_d = hcb_pkg::OP_SIFT_L;
      hcb_pkg::OP_SIFT_L:    state_d = sts_i.sift_end ? ret_op : hcb_pkg::OP_SIFT_R;
      hcb_pkg::OP_SIFT_R:    state_d = hcb_pkg::OP_SIFT_RW;
      hcb_pkg::OP_SIFT_RW:   state_d = hcb_pkg::OP_SIFT_PICK;
      hcb_pkg::OP_SIFT_PICK: state_d = sts_i.sift_stay ? ret_op : hcb_pkg::OP_SIFT_L;
      hcb_pkg::OP_MERGE_CHK: begin
        ret_d   = hcb_pkg::RET_TAKE1;
        state_d = sts_i.fill_gt1 ? hcb_pkg::OP_TAKE_TOP : hcb_pkg::OP_WALK_ROOT;
      end
      hcb_pkg::OP_TAKE_TOP:  state_d = hcb_pkg::OP_TAKE_LAST;
      hcb_pkg::OP_TAKE_LAST: state_d = hcb_pkg::OP_TAKE_MOVE;
      hcb_pkg::OP_TAKE_MOVE: state_d = hcb_pkg::OP_SIFT_WT;
      hcb_pkg::OP_TAKE_NEXT: begin
        ret_d   = hcb_pkg::RET_TAKE2;
        state_d = hcb_pkg::OP_TAKE_TOP;
      end
      hcb_pkg::OP_SUM_A:     state_d = hcb_pkg::OP_SUM_B;
      hcb_pkg::OP_SUM_B:     state_d = hcb_pkg::OP_SUM_WR;
      hcb_pkg::OP_SUM_WR:    state_d = hcb_pkg::OP_UP_CHK;
      hcb_pkg::OP_UP_CHK:    state_d = sts_i.m_zero ? hcb_pkg::OP_NODE_NEXT : hcb_pkg::OP_UP_SLOT;
      hcb_pkg::OP_UP_SLOT:   state_d = hcb_pkg::OP_UP_CMP;
      hcb_pkg::OP_UP_CMP:    state_d = sts_i.up_less ? hcb_pkg::OP_UP_CHK : hcb_pkg::OP_NODE_NEXT;
      hcb_pkg::OP_NODE_NEXT: state_d = hcb_pkg::OP_MERGE_CHK;
      hcb_pkg::OP_WALK_ROOT: state_d = hcb_pkg::OP_WALK_PUSH0;
      hcb_pkg::OP_WALK_PUSH0: state_d = hcb_pkg::OP_WALK_POP;
      hcb_pkg::OP_WALK_POP:  state_d = sts_i.sp_zero ? hcb_pkg::OP_FINISH : hcb_pkg::OP_WALK_READ;
      hcb_pkg::OP_WALK_READ: state_d = sts_i.is_leaf ? hcb_pkg::OP_WALK_LEAF : hcb_pkg::OP_WALK_RIGHT;
      hcb_pkg::OP_WALK_LEAF: state_d = hcb_pkg::OP_WALK_EMIT;
      hcb_pkg::OP_WALK_EMIT: begin
        if (sts_i.emit_ok) state_d = hcb_pkg::OP_WALK_POP;
      end
      hcb_pkg::OP_WALK_RIGHT: state_d = hcb_pkg::OP_WALK_LEFT;
      hcb_pkg::OP_WALK_LEFT:  state_d = hcb_pkg::OP_WALK_POP;
      hcb_pkg::OP_FINISH: begin
        if (sts_i.out_free) state_d = hcb_pkg::OP_IDLE;
      end
      default: state_d = hcb_pkg::OP_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/hcb_dp.sv =====
// datapath of the huffman code builder: symbol, node, heap and stack memories,
// sift and walk registers, output register; depends on hcb_pkg, hcb_ram, interfaces
`default_nettype none

module hcb_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hcb_pkg::hcb_cmd_t cmd_i,
  output hcb_pkg::hcb_sts_t      sts_o,
  hcb_in_if.sink                 in_i,
  hcb_out_if.source              out_o
);

  localparam int unsigned PB_W = hcb_pkg::DEPTH_W + hcb_pkg::WEIGHT_W;
  localparam int unsigned PY_W = hcb_pkg::BYTES_W + hcb_pkg::WEIGHT_W;

  // memories
  logic                         heap_we, wt_we, ch_we, sym_we, stk_we;
  logic [hcb_pkg::SLOT_AW-1:0]  heap_wa, heap_ra, sym_wa, sym_ra, stk_wa, stk_ra;
  logic [hcb_pkg::IDX_W-1:0]    heap_wd, heap_rd;
  logic [hcb_pkg::IDX_W-1:0]    wt_wa, wt_ra, ch_wa, ch_ra;
  logic [hcb_pkg::WEIGHT_W-1:0] wt_wd, wt_rd;
  logic [hcb_pkg::CHILD_W-1:0]  ch_wd, ch_rd;
  logic [hcb_pkg::STORE_W-1:0]  sym_wd, sym_rd;
  logic [hcb_pkg::STACK_W-1:0]  stk_wd, stk_rd;

  hcb_ram #(.WIDTH(hcb_pkg::IDX_W), .DEPTH(hcb_pkg::MAX_SYMBOLS)) u_heap (
    .clk_i, .we_i(heap_we), .waddr_i(heap_wa), .wdata_i(heap_wd),
    .raddr_i(heap_ra), .rdata_o(heap_rd));
  hcb_ram #(.WIDTH(hcb_pkg::WEIGHT_W), .DEPTH(hcb_pkg::NODE_MAX)) u_weight (
    .clk_i, .we_i(wt_we), .waddr_i(wt_wa), .wdata_i(wt_wd),
    .raddr_i(wt_ra), .rdata_o(wt_rd));
  hcb_ram #(.WIDTH(hcb_pkg::CHILD_W), .DEPTH(hcb_pkg::NODE_MAX)) u_child (
    .clk_i, .we_i(ch_we), .waddr_i(ch_wa), .wdata_i(ch_wd),
    .raddr_i(ch_ra), .rdata_o(ch_rd));
  hcb_ram #(.WIDTH(hcb_pkg::STORE_W), .DEPTH(hcb_pkg::MAX_SYMBOLS)) u_sym (
    .clk_i, .we_i(sym_we), .waddr_i(sym_wa), .wdata_i(sym_wd),
    .raddr_i(sym_ra), .rdata_o(sym_rd));
  hcb_ram #(.WIDTH(hcb_pkg::STACK_W), .DEPTH(hcb_pkg::MAX_SYMBOLS)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .raddr_i(stk_ra), .rdata_o(stk_rd));

  // control registers
  logic [hcb_pkg::CNT_W-1:0]    n_q, fill_q, sp_q;
  logic                         pend_v_q, out_v_q, out_v_d;
  logic [hcb_pkg::BSUM_W-1:0]   bit_sum_q;
  logic [hcb_pkg::ISUM_W-1:0]   byte_sum_q;

  // payload registers
  logic [hcb_pkg::SLOT_AW-1:0]  bi_q, bld_q, i_q, m_q;
  logic [hcb_pkg::IDX_W-1:0]    slot_i_q, slot_l_q, slot_r_q, slot_p_q, top_q, rt_q;
  logic [hcb_pkg::IDX_W-1:0]    next_q, lft_q;
  logic [hcb_pkg::WEIGHT_W-1:0] w_i_q, w_l_q, wa_q, wnew_q;
  logic [hcb_pkg::DEPTH_W-1:0]  e_depth_q, lf_depth_q, pend_depth_q;
  logic [hcb_pkg::CODE_W-1:0]   e_code_q, lf_code_q, pend_code_q;
  logic [hcb_pkg::SYM_W-1:0]    lf_sym_q, pend_sym_q;
  logic [hcb_pkg::SYM_W-1:0]    o_sym_q;
  logic [hcb_pkg::DEPTH_W-1:0]  o_len_q;
  logic [hcb_pkg::CODE_W-1:0]   o_code_q;
  logic [hcb_pkg::BSUM_W-1:0]   o_bits_q;
  logic [hcb_pkg::ISUM_W-1:0]   o_bytes_q;
  logic                         o_last_q;

  // combinational helpers
  logic                         in_acc, store_ok, out_free, push_ok;
  logic [hcb_pkg::SLOT_AW:0]    l_idx;
  logic [hcb_pkg::SLOT_AW+1:0]  r_idx;
  logic                         r_ok, pick_l, pick_r, stay;
  logic [hcb_pkg::SLOT_AW-1:0]  i_new, p_idx;
  logic [hcb_pkg::IDX_W-1:0]    slot_s;
  logic [hcb_pkg::WEIGHT_W-1:0] w_after_l;
  logic [hcb_pkg::IDX_W-1:0]    s_node;
  logic [hcb_pkg::DEPTH_W-1:0]  s_depth;
  logic [hcb_pkg::CODE_W-1:0]   s_code;
  logic [PB_W-1:0]              prod_b;
  logic [PY_W-1:0]              prod_y;
  logic [hcb_pkg::BSUM_W:0]     sum_b;
  logic [PY_W:0]                sum_y;

  assign in_acc   = in_i.valid && in_i.ready;
  assign store_ok = n_q < hcb_pkg::CNT_W'(hcb_pkg::MAX_SYMBOLS);
  assign out_free = !out_v_q || out_o.ready;
  assign push_ok  = sp_q <= hcb_pkg::CNT_W'(hcb_pkg::MAX_SYMBOLS - 2);

  assign l_idx = {i_q, 1'b1};
  assign r_idx = {1'b0, i_q, 1'b0} + (hcb_pkg::SLOT_AW + 2)'(2);
  assign r_ok  = r_idx < (hcb_pkg::SLOT_AW + 2)'(fill_q);

  assign pick_l    = w_l_q < w_i_q;
  assign w_after_l = pick_l ? w_l_q : w_i_q;
  assign pick_r    = r_ok && (wt_rd < w_after_l);
  assign stay      = !pick_l && !pick_r;
  assign i_new     = pick_r ? r_idx[hcb_pkg::SLOT_AW-1:0] : l_idx[hcb_pkg::SLOT_AW-1:0];
  assign slot_s    = stay ? slot_i_q : (pick_r ? slot_r_q : slot_l_q);
  assign p_idx     = (m_q - hcb_pkg::SLOT_AW'(1)) >> 1;

  assign {s_node, s_depth, s_code} = stk_rd;

  assign prod_b = PB_W'(e_depth_q) * PB_W'(wt_rd);
  assign prod_y = PY_W'(sym_rd[hcb_pkg::STORE_W-1:hcb_pkg::SYM_W]) * PY_W'(wt_rd);
  assign sum_b  = (hcb_pkg::BSUM_W + 1)'(bit_sum_q) + (hcb_pkg::BSUM_W + 1)'(prod_b);
  assign sum_y  = (PY_W + 1)'(byte_sum_q) + (PY_W + 1)'(prod_y);

  // status
  always_comb begin
    sts_o.acc_last  = in_acc && in_i.last;
    sts_o.init_done = {1'b0, bi_q} == (n_q - hcb_pkg::CNT_W'(1));
    sts_o.one_sym   = n_q == hcb_pkg::CNT_W'(1);
    sts_o.bld_zero  = bld_q == '0;
    sts_o.sift_end  = l_idx >= fill_q;
    sts_o.sift_stay = stay;
    sts_o.fill_gt1  = fill_q > hcb_pkg::CNT_W'(1);
    sts_o.m_zero    = m_q == '0;
    sts_o.up_less   = wnew_q < wt_rd;
    sts_o.sp_zero   = sp_q == '0;
    sts_o.is_leaf   = s_node < hcb_pkg::IDX_W'(n_q);
    sts_o.emit_ok   = !pend_v_q || out_free;
    sts_o.out_free  = out_free;
    sts_o.pend_v    = pend_v_q;
  end

  // memory ports
  always_comb begin
    heap_we = 1'b0; heap_wa = '0; heap_wd = '0; heap_ra = '0;
    wt_we   = 1'b0; wt_wa   = '0; wt_wd   = '0; wt_ra   = heap_rd;
    ch_we   = 1'b0; ch_wa   = next_q; ch_wd = {top_q, rt_q}; ch_ra = s_node;
    sym_we  = 1'b0; sym_wa  = n_q[hcb_pkg::SLOT_AW-1:0];
    sym_wd  = {in_i.symbol_bytes, in_i.symbol};
    sym_ra  = s_node[hcb_pkg::SLOT_AW-1:0];
    stk_we  = 1'b0; stk_wa  = '0; stk_wd  = '0;
    stk_ra  = sp_q[hcb_pkg::SLOT_AW-1:0] - hcb_pkg::SLOT_AW'(1);
    unique case (cmd_i.op)
      hcb_pkg::OP_IDLE: begin
        sym_we = in_acc && store_ok;
        wt_we  = in_acc && store_ok;
        wt_wa  = hcb_pkg::IDX_W'(n_q);
        wt_wd  = hcb_pkg::WEIGHT_W'(in_i.count[hcb_pkg::COUNT_BITS-1:0]);
      end
      hcb_pkg::OP_INIT: begin
        heap_we = 1'b1;
        heap_wa = bi_q;
        heap_wd = hcb_pkg::IDX_W'(bi_q);
      end
      hcb_pkg::OP_SIFT_LOAD: heap_ra = bld_q;
      hcb_pkg::OP_SIFT_L: begin
        heap_ra = l_idx[hcb_pkg::SLOT_AW-1:0];
        heap_we = l_idx >= fill_q;
        heap_wa = i_q;
        heap_wd = slot_i_q;
      end
      hcb_pkg::OP_SIFT_R: heap_ra = r_idx[hcb_pkg::SLOT_AW-1:0];
      hcb_pkg::OP_SIFT_PICK: begin
        heap_we = 1'b1;
        heap_wa = i_q;
        heap_wd = slot_s;
      end
      hcb_pkg::OP_TAKE_LAST: heap_ra = fill_q[hcb_pkg::SLOT_AW-1:0] - hcb_pkg::SLOT_AW'(1);
      hcb_pkg::OP_SUM_A: wt_ra = rt_q;
      hcb_pkg::OP_SUM_B: wt_ra = top_q;
      hcb_pkg::OP_SUM_WR: begin
        wt_we = 1'b1;
        wt_wa = next_q;
        wt_wd = wa_q + wt_rd;
        ch_we = 1'b1;
      end
      hcb_pkg::OP_UP_CHK: begin
        heap_ra = p_idx;
        heap_we = m_q == '0;
        heap_wa = m_q;
        heap_wd = next_q;
      end
      hcb_pkg::OP_UP_CMP: begin
        heap_we = 1'b1;
        heap_wa = m_q;
        heap_wd = (wnew_q < wt_rd) ? slot_p_q : next_q;
      end
      hcb_pkg::OP_WALK_PUSH0: begin
        stk_we = 1'b1;
        stk_wd = {heap_rd, hcb_pkg::DEPTH_W'(0), hcb_pkg::CODE_W'(0)};
      end
      hcb_pkg::OP_WALK_READ: wt_ra = s_node;
      hcb_pkg::OP_WALK_RIGHT: begin
        stk_we = push_ok;
        stk_wa = sp_q[hcb_pkg::SLOT_AW-1:0];
        stk_wd = {ch_rd[hcb_pkg::IDX_W-1:0], e_depth_q + hcb_pkg::DEPTH_W'(1),
                  e_code_q[hcb_pkg::CODE_W-2:0], 1'b1};
      end
      hcb_pkg::OP_WALK_LEFT: begin
        stk_we = push_ok;
        stk_wa = sp_q[hcb_pkg::SLOT_AW-1:0] + hcb_pkg::SLOT_AW'(1);
        stk_wd = {lft_q, e_depth_q + hcb_pkg::DEPTH_W'(1),
                  e_code_q[hcb_pkg::CODE_W-2:0], 1'b0};
      end
      default: ;
    endcase
  end

  // output valid
  always_comb begin
    out_v_d = out_v_q && !out_o.ready;
    if (cmd_i.op == hcb_pkg::OP_WALK_EMIT && pend_v_q && out_free) out_v_d = 1'b1;
    if (cmd_i.op == hcb_pkg::OP_FINISH && out_free) out_v_d = 1'b1;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q        <= '0;
      fill_q     <= '0;
      sp_q       <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      bit_sum_q  <= '0;
      byte_sum_q <= '0;
    end else begin
      out_v_q <= out_v_d;
      unique case (cmd_i.op)
        hcb_pkg::OP_IDLE: begin
          if (in_acc && store_ok) n_q <= n_q + hcb_pkg::CNT_W'(1);
        end
        hcb_pkg::OP_INIT: begin
          if ({1'b0, bi_q} == (n_q - hcb_pkg::CNT_W'(1))) fill_q <= n_q;
        end
        hcb_pkg::OP_TAKE_MOVE: fill_q <= fill_q - hcb_pkg::CNT_W'(1);
        hcb_pkg::OP_SUM_WR:    fill_q <= fill_q + hcb_pkg::CNT_W'(1);
        hcb_pkg::OP_WALK_PUSH0: sp_q <= hcb_pkg::CNT_W'(1);
        hcb_pkg::OP_WALK_POP: begin
          if (sp_q != '0) sp_q <= sp_q - hcb_pkg::CNT_W'(1);
        end
        hcb_pkg::OP_WALK_LEFT: begin
          if (push_ok) sp_q <= sp_q + hcb_pkg::CNT_W'(2);
        end
        hcb_pkg::OP_WALK_LEAF: begin
          bit_sum_q  <= sum_b[hcb_pkg::BSUM_W] ? '1 : sum_b[hcb_pkg::BSUM_W-1:0];
          byte_sum_q <= (sum_y[PY_W:hcb_pkg::ISUM_W] != '0) ? '1 :
                        sum_y[hcb_pkg::ISUM_W-1:0];
        end
        hcb_pkg::OP_WALK_EMIT: begin
          if (!pend_v_q || out_free) pend_v_q <= 1'b1;
        end
        hcb_pkg::OP_FINISH: begin
          if (out_free) begin
            pend_v_q   <= 1'b0;
            n_q        <= '0;
            fill_q     <= '0;
            bit_sum_q  <= '0;
            byte_sum_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      hcb_pkg::OP_IDLE: bi_q <= '0;
      hcb_pkg::OP_INIT: begin
        bi_q   <= bi_q + hcb_pkg::SLOT_AW'(1);
        next_q <= hcb_pkg::IDX_W'(n_q);
        bld_q  <= hcb_pkg::SLOT_AW'((n_q - hcb_pkg::CNT_W'(2)) >> 1);
      end
      hcb_pkg::OP_BLD_NEXT:  bld_q <= bld_q - hcb_pkg::SLOT_AW'(1);
      hcb_pkg::OP_SIFT_LOAD: i_q <= bld_q;
      hcb_pkg::OP_SIFT_SLOT: slot_i_q <= heap_rd;
      hcb_pkg::OP_SIFT_WT:   w_i_q <= wt_rd;
      hcb_pkg::OP_SIFT_R:    slot_l_q <= heap_rd;
      hcb_pkg::OP_SIFT_RW: begin
        w_l_q    <= wt_rd;
        slot_r_q <= heap_rd;
      end
      hcb_pkg::OP_SIFT_PICK: begin
        if (!stay) i_q <= i_new;
      end
      hcb_pkg::OP_TAKE_LAST: top_q <= heap_rd;
      hcb_pkg::OP_TAKE_MOVE: begin
        slot_i_q <= heap_rd;
        i_q      <= '0;
      end
      hcb_pkg::OP_TAKE_NEXT: rt_q <= top_q;
      hcb_pkg::OP_SUM_B:     wa_q <= wt_rd;
      hcb_pkg::OP_SUM_WR: begin
        wnew_q <= wa_q + wt_rd;
        m_q    <= fill_q[hcb_pkg::SLOT_AW-1:0];
      end
      hcb_pkg::OP_UP_SLOT: slot_p_q <= heap_rd;
      hcb_pkg::OP_UP_CMP: begin
        if (wnew_q < wt_rd) m_q <= p_idx;
      end
      hcb_pkg::OP_NODE_NEXT: next_q <= next_q + hcb_pkg::IDX_W'(1);
      hcb_pkg::OP_WALK_READ: begin
        e_depth_q <= s_depth;
        e_code_q  <= s_code;
      end
      hcb_pkg::OP_WALK_LEAF: begin
        lf_sym_q   <= sym_rd[hcb_pkg::SYM_W-1:0];
        lf_depth_q <= e_depth_q;
        lf_code_q  <= e_code_q;
      end
      hcb_pkg::OP_WALK_EMIT: begin
        if (!pend_v_q || out_free) begin
          pend_sym_q   <= lf_sym_q;
          pend_depth_q <= lf_depth_q;
          pend_code_q  <= lf_code_q;
        end
        if (pend_v_q && out_free) begin
          o_sym_q   <= pend_sym_q;
          o_len_q   <= pend_depth_q;
          o_code_q  <= pend_code_q;
          o_bits_q  <= '0;
          o_bytes_q <= '0;
          o_last_q  <= 1'b0;
        end
      end
      hcb_pkg::OP_WALK_RIGHT: lft_q <= ch_rd[hcb_pkg::CHILD_W-1:hcb_pkg::IDX_W];
      hcb_pkg::OP_FINISH: begin
        if (out_free) begin
          o_sym_q   <= pend_sym_q;
          o_len_q   <= pend_depth_q;
          o_code_q  <= pend_code_q;
          o_bits_q  <= bit_sum_q;
          o_bytes_q <= byte_sum_q;
          o_last_q  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign in_i.ready        = cmd_i.op == hcb_pkg::OP_IDLE;
  assign out_o.valid       = out_v_q;
  assign out_o.symbol_res  = o_sym_q;
  assign out_o.code_length = o_len_q;
  assign out_o.code_bits   = o_code_q;
  assign out_o.total_bits  = o_bits_q;
  assign out_o.input_bytes = o_bytes_q;
  assign out_o.last_res    = o_last_q;

endmodule

`default_nettype wire

// ===== src/huffman_code_builder_core.sv =====
// huffman code builder top level: input and output channels, sequencer and datapath
// depends on hcb_pkg, hcb_in_if, hcb_out_if, hcb_ctrl, hcb_dp
//
// in_i takes one symbol beat per cycle (bytes, byte length, count) while the
// block is loading; the beat marked last starts the build and in_i.ready drops
// until the final code has been handed to the output register.
// The build writes n heap slots, then sifts the heap down one level at a time,
// and then does n-1 merges of two extractions and one sift-up each, through
// the single read port of the heap and weight memories. The depth-first walk
// pops each tree node and pushes both children of an inner node or emits a
// leaf; it stalls with the output, one code beat per leaf.
// out_o presents one code beat per leaf; total_bits and input_bytes are nonzero
// only on the beat with last_res. One leaf is held back so that the final beat
// can be marked; a stalled out_o holds its beat and stalls the walk.
// Reset clears the counters, sums and both valid flags; memory contents are not
// cleared and need no clearing pass.
`default_nettype none

module huffman_code_builder_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hcb_in_if.sink    in_i,
  hcb_out_if.source out_o
);

  hcb_pkg::hcb_cmd_t cmd;
  hcb_pkg::hcb_sts_t sts;

  hcb_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  hcb_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i (cmd),
    .sts_o (sts),
    .in_i  (in_i),
    .out_o (out_o)
  );

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !sts.pend_v)
    else $error("leaf pending while loading");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.symbol_res) &&
      $stable(out_o.code_bits) && $stable(out_o.last_res))
    else $error("code beat changed while stalled");

  a_sums_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.last_res |-> out_o.total_bits == '0 && out_o.input_bytes == '0)
    else $error("sums on a non-final code");

endmodule

`default_nettype wire
